// File: rtl/core/fall_detect_trigger_chain_assert.svh
// ----------------------------------------------------------------------------
// fall detector assertion macros
// shared property forms for the checker, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef FALL_DETECT_TRIGGER_CHAIN_ASSERT_SVH
`define FALL_DETECT_TRIGGER_CHAIN_ASSERT_SVH

// same-cycle implication, off while reset is low
`define FDTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define FDTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also covers the reset cycles
`define FDTC_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/fdtc_pkg.sv
// ----------------------------------------------------------------------------
// fdtc_pkg
// types, offsets and reset values shared by the fall detector modules
// ----------------------------------------------------------------------------
package fdtc_pkg;

    // sensor offsets, applied as sample + offset on 17-bit signed values
    localparam logic signed [16:0] ACC_OFF_X = -17'sd2050;
    localparam logic signed [16:0] ACC_OFF_Y = -17'sd77;
    localparam logic signed [16:0] ACC_OFF_Z = -17'sd1947;
    localparam logic signed [16:0] GYR_OFF_X = 17'sd270;
    localparam logic signed [16:0] GYR_OFF_Y = -17'sd351;
    localparam logic signed [16:0] GYR_OFF_Z = 17'sd136;

    // samples from the turn trigger to the stillness check, trigger sample included
    localparam logic [3:0] SETTLE_COUNT = 4'd10;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_LOW_ACCEL_SQ  = 3'd0,
        CFG_HIGH_ACCEL_SQ = 3'd1,
        CFG_TURN_MIN_SQ   = 3'd2,
        CFG_TURN_MAX_SQ   = 3'd3,
        CFG_STILL_MAX_SQ  = 3'd4,
        CFG_FF_WINDOW     = 3'd5,
        CFG_TURN_WINDOW   = 3'd6,
        CFG_HOLD_SAMPLES  = 3'd7
    } t_cfg_idx;

    // reset values of the configuration registers
    localparam logic [31:0] RST_LOW_ACCEL_SQ  = 32'd24159191;
    localparam logic [31:0] RST_HIGH_ACCEL_SQ = 32'd386547057;
    localparam logic [31:0] RST_TURN_MIN_SQ   = 32'd15461411;
    localparam logic [31:0] RST_TURN_MAX_SQ   = 32'd2748695184;
    localparam logic [31:0] RST_STILL_MAX_SQ  = 32'd1717934;
    localparam logic [3:0]  RST_FF_WINDOW     = 4'd6;
    localparam logic [3:0]  RST_TURN_WINDOW   = 4'd6;
    localparam logic [7:0]  RST_HOLD_SAMPLES  = 8'd50;

    typedef struct packed {
        logic [31:0] low_accel_sq;
        logic [31:0] high_accel_sq;
        logic [31:0] turn_min_sq;
        logic [31:0] turn_max_sq;
        logic [31:0] still_max_sq;
        logic [3:0]  free_fall_window;
        logic [3:0]  turn_window;
        logic [7:0]  hold_samples;
    } t_cfg;

    // threshold results of one sample
    typedef struct packed {
        logic low_accel;
        logic high_accel;
        logic turn_rate;
        logic still;
    } t_cmp;

    // square of an offset-corrected axis, at most 34818^2 < 2^31
    function automatic logic [30:0] sq17(input logic signed [16:0] v);
        logic signed [33:0] p;
        p = v * v;
        return p[30:0];
    endfunction

    // sign-extend a raw sample and add its offset
    function automatic logic signed [16:0] adj(input logic signed [15:0] x,
                                               input logic signed [16:0] off);
        return {x[15], x} + off;
    endfunction

endpackage

// File: rtl/core/fdtc_cfg.sv
// ----------------------------------------------------------------------------
// fdtc_cfg
// configuration register file, written through its own valid/ready channel
// ----------------------------------------------------------------------------
module fdtc_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output fdtc_pkg::t_cfg      o_cfg
);

    fdtc_pkg::t_cfg r_cfg;

    // always able to take a write
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_accel_sq     <= fdtc_pkg::RST_LOW_ACCEL_SQ;
            r_cfg.high_accel_sq    <= fdtc_pkg::RST_HIGH_ACCEL_SQ;
            r_cfg.turn_min_sq      <= fdtc_pkg::RST_TURN_MIN_SQ;
            r_cfg.turn_max_sq      <= fdtc_pkg::RST_TURN_MAX_SQ;
            r_cfg.still_max_sq     <= fdtc_pkg::RST_STILL_MAX_SQ;
            r_cfg.free_fall_window <= fdtc_pkg::RST_FF_WINDOW;
            r_cfg.turn_window      <= fdtc_pkg::RST_TURN_WINDOW;
            r_cfg.hold_samples     <= fdtc_pkg::RST_HOLD_SAMPLES;
        end else if (i_cfg_valid) begin
            case (fdtc_pkg::t_cfg_idx'(i_cfg_index))
                fdtc_pkg::CFG_LOW_ACCEL_SQ:  r_cfg.low_accel_sq     <= i_cfg_data;
                fdtc_pkg::CFG_HIGH_ACCEL_SQ: r_cfg.high_accel_sq    <= i_cfg_data;
                fdtc_pkg::CFG_TURN_MIN_SQ:   r_cfg.turn_min_sq      <= i_cfg_data;
                fdtc_pkg::CFG_TURN_MAX_SQ:   r_cfg.turn_max_sq      <= i_cfg_data;
                fdtc_pkg::CFG_STILL_MAX_SQ:  r_cfg.still_max_sq     <= i_cfg_data;
                fdtc_pkg::CFG_FF_WINDOW:     r_cfg.free_fall_window <= i_cfg_data[3:0];
                fdtc_pkg::CFG_TURN_WINDOW:   r_cfg.turn_window      <= i_cfg_data[3:0];
                fdtc_pkg::CFG_HOLD_SAMPLES:  r_cfg.hold_samples     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/core/fdtc_mag.sv
// ----------------------------------------------------------------------------
// fdtc_mag
// input register, then squared magnitudes and threshold compares
// ----------------------------------------------------------------------------
module fdtc_mag (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fdtc_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_accel_x,
    input  logic signed [15:0]  i_accel_y,
    input  logic signed [15:0]  i_accel_z,
    input  logic signed [15:0]  i_gyro_x,
    input  logic signed [15:0]  i_gyro_y,
    input  logic signed [15:0]  i_gyro_z,
    output logic                o_valid,
    input  logic                i_ready,
    output fdtc_pkg::t_cmp      o_cmp
);

    logic               r_v0;
    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy, r_gz;
    logic [30:0]        sq_a [3];
    logic [30:0]        sq_g [3];
    fdtc_pkg::t_cmp     cmp;
    logic [31:0]        mag_a, mag_g;

    // input register moves when empty or when the chain takes its item
    assign o_ready = !r_v0 || i_ready;
    assign o_valid = r_v0;
    assign o_cmp   = cmp;

    // squares of the offset-corrected axes
    assign sq_a[0] = fdtc_pkg::sq17(fdtc_pkg::adj(r_ax, fdtc_pkg::ACC_OFF_X));
    assign sq_a[1] = fdtc_pkg::sq17(fdtc_pkg::adj(r_ay, fdtc_pkg::ACC_OFF_Y));
    assign sq_a[2] = fdtc_pkg::sq17(fdtc_pkg::adj(r_az, fdtc_pkg::ACC_OFF_Z));
    assign sq_g[0] = fdtc_pkg::sq17(fdtc_pkg::adj(r_gx, fdtc_pkg::GYR_OFF_X));
    assign sq_g[1] = fdtc_pkg::sq17(fdtc_pkg::adj(r_gy, fdtc_pkg::GYR_OFF_Y));
    assign sq_g[2] = fdtc_pkg::sq17(fdtc_pkg::adj(r_gz, fdtc_pkg::GYR_OFF_Z));

    // sums of squares, never above 2^32 - 1
    assign mag_a = 32'(sq_a[0]) + 32'(sq_a[1]) + 32'(sq_a[2]);
    assign mag_g = 32'(sq_g[0]) + 32'(sq_g[1]) + 32'(sq_g[2]);

    // threshold compares
    always_comb begin
        cmp.low_accel  = mag_a <= i_cfg.low_accel_sq;
        cmp.high_accel = mag_a >= i_cfg.high_accel_sq;
        cmp.turn_rate  = (mag_g >= i_cfg.turn_min_sq) && (mag_g <= i_cfg.turn_max_sq);
        cmp.still      = mag_g <= i_cfg.still_max_sq;
    end

    // input valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (o_ready) begin
            r_v0 <= i_valid;
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
            r_gx <= i_gyro_x;
            r_gy <= i_gyro_y;
            r_gz <= i_gyro_z;
        end
    end

endmodule

// File: rtl/core/fdtc_chain.sv
// ----------------------------------------------------------------------------
// fdtc_chain
// free-fall, impact and turn triggers, settle check, fall hold, result register
// ----------------------------------------------------------------------------
module fdtc_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fdtc_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  fdtc_pkg::t_cmp      i_cmp,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_fall_detected_flag,
    output logic                o_armed_free_fall,
    output logic                o_armed_impact,
    output logic                o_armed_turn
);

    logic       r_low_phase, r_impact_phase, r_turn_phase, r_fall_hold;
    logic [3:0] r_low_timer, r_impact_timer, r_settle_timer;
    logic [7:0] r_hold_timer;
    logic       n_low_phase, n_impact_phase, n_turn_phase, n_fall_hold;
    logic [3:0] n_low_timer, n_impact_timer, n_settle_timer;
    logic [7:0] n_hold_timer;
    logic       fall;
    logic       r_out_valid;
    logic       r_out_fall, r_out_low, r_out_impact, r_out_turn;
    logic       take;

    // result register frees up when empty or being taken
    assign o_ready              = !r_out_valid || i_out_ready;
    assign take                 = i_valid && o_ready;
    assign o_out_valid          = r_out_valid;
    assign o_fall_detected_flag = r_out_fall;
    assign o_armed_free_fall    = r_out_low;
    assign o_armed_impact       = r_out_impact;
    assign o_armed_turn         = r_out_turn;

    // trigger chain, in order of evaluation
    always_comb begin
        n_low_phase    = r_low_phase;
        n_impact_phase = r_impact_phase;
        n_turn_phase   = r_turn_phase;
        n_fall_hold    = r_fall_hold;
        n_low_timer    = r_low_timer;
        n_impact_timer = r_impact_timer;
        n_settle_timer = r_settle_timer;
        n_hold_timer   = r_hold_timer;
        fall           = 1'b0;

        // free fall opens unless an impact window is running
        if (i_cmp.low_accel && !n_impact_phase) begin
            n_low_phase = 1'b1;
        end
        if (n_low_phase) begin
            n_low_timer = n_low_timer + 4'd1;
            if (i_cmp.high_accel) begin
                n_impact_phase = 1'b1;
                n_low_phase    = 1'b0;
                n_low_timer    = 4'd0;
            end
        end

        // impact waits for a turn
        if (n_impact_phase) begin
            n_impact_timer = n_impact_timer + 4'd1;
            if (i_cmp.turn_rate) begin
                n_turn_phase   = 1'b1;
                n_impact_phase = 1'b0;
                n_impact_timer = 4'd0;
            end
        end

        // settle, then check stillness
        if (n_turn_phase) begin
            n_settle_timer = n_settle_timer + 4'd1;
            if (n_settle_timer >= fdtc_pkg::SETTLE_COUNT) begin
                fall           = i_cmp.still;
                n_turn_phase   = 1'b0;
                n_settle_timer = 4'd0;
            end
        end
        if (fall) begin
            n_fall_hold = 1'b1;
        end

        // window timeouts
        if (n_impact_timer >= i_cfg.turn_window) begin
            n_impact_phase = 1'b0;
            n_impact_timer = 4'd0;
        end
        if (n_low_timer >= i_cfg.free_fall_window) begin
            n_low_phase = 1'b0;
            n_low_timer = 4'd0;
        end

        // fall hold counter, detection sample counts as the first
        if (n_fall_hold) begin
            n_hold_timer = n_hold_timer + 8'd1;
            if (n_hold_timer >= i_cfg.hold_samples) begin
                n_fall_hold  = 1'b0;
                n_hold_timer = 8'd0;
            end
        end
    end

    // trigger state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_phase    <= 1'b0;
            r_impact_phase <= 1'b0;
            r_turn_phase   <= 1'b0;
            r_fall_hold    <= 1'b0;
            r_low_timer    <= 4'd0;
            r_impact_timer <= 4'd0;
            r_settle_timer <= 4'd0;
            r_hold_timer   <= 8'd0;
            r_out_valid    <= 1'b0;
        end else begin
            if (take) begin
                r_low_phase    <= n_low_phase;
                r_impact_phase <= n_impact_phase;
                r_turn_phase   <= n_turn_phase;
                r_fall_hold    <= n_fall_hold;
                r_low_timer    <= n_low_timer;
                r_impact_timer <= n_impact_timer;
                r_settle_timer <= n_settle_timer;
                r_hold_timer   <= n_hold_timer;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_fall   <= n_fall_hold;
            r_out_low    <= n_low_phase;
            r_out_impact <= n_impact_phase;
            r_out_turn   <= n_turn_phase;
        end
    end

endmodule

// File: rtl/core/fall_detect_trigger_chain.sv
// ----------------------------------------------------------------------------
// fall_detect_trigger_chain
// throughput: one sample per cycle, one result per sample, output stalls hold the input
// datapath: input register, squares, sums, compares and trigger update, result register
// reset: synchronous active low, clears triggers, timers and valids, loads default thresholds
// ----------------------------------------------------------------------------
module fall_detect_trigger_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [15:0]  i_accel_x,
    input  logic signed [15:0]  i_accel_y,
    input  logic signed [15:0]  i_accel_z,
    input  logic signed [15:0]  i_gyro_x,
    input  logic signed [15:0]  i_gyro_y,
    input  logic signed [15:0]  i_gyro_z,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_fall_detected_flag,
    output logic                o_armed_free_fall,
    output logic                o_armed_impact,
    output logic                o_armed_turn
);

    fdtc_pkg::t_cfg cfg;
    fdtc_pkg::t_cmp cmp;
    logic           cmp_valid;
    logic           cmp_ready;

    // configuration registers
    fdtc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // magnitudes and compares
    fdtc_mag u_mag (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_accel_x (i_accel_x),
        .i_accel_y (i_accel_y),
        .i_accel_z (i_accel_z),
        .i_gyro_x  (i_gyro_x),
        .i_gyro_y  (i_gyro_y),
        .i_gyro_z  (i_gyro_z),
        .o_valid   (cmp_valid),
        .i_ready   (cmp_ready),
        .o_cmp     (cmp)
    );

    // trigger chain and result register
    fdtc_chain u_chain (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (cfg),
        .i_valid              (cmp_valid),
        .o_ready              (cmp_ready),
        .i_cmp                (cmp),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_fall_detected_flag (o_fall_detected_flag),
        .o_armed_free_fall    (o_armed_free_fall),
        .o_armed_impact       (o_armed_impact),
        .o_armed_turn         (o_armed_turn)
    );

endmodule

// File: rtl/core/fdtc_checker.sv
// ----------------------------------------------------------------------------
// fdtc_checker
// port-level checks on the fall detector, bound to the top level
// ----------------------------------------------------------------------------
`include "fall_detect_trigger_chain_assert.svh"

module fdtc_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_in_ready,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic                o_armed_free_fall,
    input  logic                o_armed_impact
);

    // a stalled result stays offered
    `FDTC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")

    // free fall is closed whenever the impact window is open
    `FDTC_ASSERT_NOW(a_phase_excl, o_out_valid, !(o_armed_free_fall && o_armed_impact), "free fall and impact armed together")

    // an empty result register lets every stage move
    `FDTC_ASSERT_NOW(a_ready_free, !o_out_valid, o_in_ready, "input stalled with empty output")

    // no result right after reset
    `FDTC_ASSERT_RST(a_rst_empty, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind fall_detect_trigger_chain fdtc_checker u_fdtc_checker (.*);
